// File: rtl/tqs_pkg.sv
// tqs_pkg: types, constants and helper functions for the quantum scheduler
// used by table_driven_priority_quantum_scheduler
package tqs_pkg;

    localparam int CAPACITY_DEF    = 16;
    localparam int TABLE_SLOTS_DEF = 8;

    localparam logic [3:0] PRIO_LOW  = 4'd1;
    localparam logic [3:0] PRIO_HIGH = 4'd10;

    localparam logic CMD_SUBMIT = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    typedef enum logic [1:0] {
        CFG_QLEN  = 2'd0,
        CFG_TLEN  = 2'd1,
        CFG_TABLE = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FREE,
        ST_MOD,
        ST_REL,
        ST_REL_WR,
        ST_DSP,
        ST_DSP_WR,
        ST_DONE
    } state_t;

    // one stored task as kept in the slot memory
    typedef struct packed {
        logic [15:0] id;
        logic [3:0]  prio;
        logic [15:0] remaining;
        logic [15:0] arrival;
        logic [31:0] stamp;
    } slot_t;

    // result waiting for the output register
    typedef struct packed {
        logic        accepted;
        logic        dispatched;
        logic [15:0] ran_id;
        logic [3:0]  new_priority;
        logic [15:0] remaining;
        logic        finished;
        logic [15:0] quantum_index;
    } res_t;

    function automatic logic [3:0] clamp_prio(input logic [3:0] p);
        logic [3:0] r;
        r = p;
        if (p < PRIO_LOW) r = PRIO_LOW;
        if (p > PRIO_HIGH) r = PRIO_HIGH;
        return r;
    endfunction

    // distance of priority p from start in upward wrapping search order
    function automatic logic [3:0] prio_rank(input logic [3:0] p, input logic [3:0] start);
        logic [3:0] r;
        if (p >= start) r = p - start;
        else r = p + PRIO_HIGH - start;
        return r;
    endfunction

endpackage

// File: rtl/tqs_ram.sv
// tqs_ram: generic single write port, single read port ram with registered read
// no package dependency
module tqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/table_driven_priority_quantum_scheduler.sv
// Priority quantum scheduler with per-priority fifo order kept by age stamps.
// One item at a time: a submit searches for the lowest free slot over the valid bits, one per
// cycle; a tick finds the slot table index (bit-serial remainder of the quantum count by the
// table length), then makes one pass over the slot memory through its single read port for
// each release, one more release pass that finds nothing, and the final dispatch pass, each
// pass followed by its write-back state; the item is taken in the idle state and the result
// is presented from the done state. Results sit in an output register; the next item is
// taken once the result has been moved into that register.
// Depends on tqs_pkg and tqs_ram.
module table_driven_priority_quantum_scheduler #(
    parameter int CAPACITY    = tqs_pkg::CAPACITY_DEF,
    parameter int TABLE_SLOTS = tqs_pkg::TABLE_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [15:0] task_id,
    input  logic [3:0]  task_priority,
    input  logic [15:0] run_time,
    input  logic [15:0] arrival_quantum,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        accepted,
    output logic        dispatched,
    output logic [15:0] ran_id,
    output logic [3:0]  new_priority,
    output logic [15:0] remaining,
    output logic        finished,
    output logic        idle,
    output logic [15:0] quantum_index
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = $bits(tqs_pkg::slot_t);

    tqs_pkg::state_t state_reg, state_next;

    logic [15:0] qlen_reg;
    logic [3:0]  tlen_reg;
    logic [31:0] table_reg;

    logic [CAPACITY-1:0] valid_reg, valid_next;
    logic [CAPACITY-1:0] ready_reg, ready_next;
    logic [31:0] stamp_cnt_reg, stamp_cnt_next;
    logic [15:0] qcount_reg, qcount_next;

    logic        cmd_reg, cmd_next;
    logic [15:0] id_reg, id_next;
    logic [3:0]  prio_reg, prio_next;
    logic [15:0] rt_reg, rt_next;
    logic [15:0] arr_reg, arr_next;

    logic [CW-1:0] scan_cnt_reg, scan_cnt_next;
    logic          ev_vld_reg, ev_vld_next;
    logic [IW-1:0] ev_idx_reg, ev_idx_next;

    logic              best_found_reg, best_found_next;
    logic [IW-1:0]     best_idx_reg, best_idx_next;
    tqs_pkg::slot_t    best_word_reg, best_word_next;
    logic [31:0]       best_age_reg, best_age_next;
    logic [3:0]        best_rank_reg, best_rank_next;

    logic [3:0] mod_cnt_reg, mod_cnt_next;
    logic [3:0] mod_rem_reg, mod_rem_next;
    logic [3:0] start_reg, start_next;

    tqs_pkg::res_t res_reg, res_next;

    logic        out_valid_reg, out_valid_next;
    tqs_pkg::res_t out_res_reg, out_res_next;
    logic        out_idle_reg, out_idle_next;

    // slot memory port
    logic           ram_we;
    logic [IW-1:0]  ram_waddr;
    tqs_pkg::slot_t ram_wdata;
    logic [SW-1:0]  ram_rdata;
    tqs_pkg::slot_t rd_word;

    tqs_ram #(
        .WIDTH (SW),
        .DEPTH (CAPACITY)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (scan_cnt_reg[IW-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_word = tqs_pkg::slot_t'(ram_rdata);

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qlen_reg  <= 16'd1;
            tlen_reg  <= 4'd1;
            table_reg <= 32'd1;
        end
        else if (cfg_valid)
        begin
            case (tqs_pkg::cfg_idx_t'(cfg_index))
                tqs_pkg::CFG_QLEN:  qlen_reg  <= cfg_data[15:0];
                tqs_pkg::CFG_TLEN:  tlen_reg  <= cfg_data[3:0];
                tqs_pkg::CFG_TABLE: table_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [3:0]  len_eff;
    logic [2:0]  entry;
    logic [15:0] ql_eff;
    logic [31:0] ev_age;
    logic [3:0]  ev_rank;
    logic        ev_match;
    logic        ev_better;
    logic        scan_end;
    logic [4:0]  mod_shift;
    tqs_pkg::slot_t upd_word;
    logic        runs_on;

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        ready_next      = ready_reg;
        stamp_cnt_next  = stamp_cnt_reg;
        qcount_next     = qcount_reg;
        cmd_next        = cmd_reg;
        id_next         = id_reg;
        prio_next       = prio_reg;
        rt_next         = rt_reg;
        arr_next        = arr_reg;
        scan_cnt_next   = scan_cnt_reg;
        ev_vld_next     = 1'b0;
        ev_idx_next     = ev_idx_reg;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_word_next  = best_word_reg;
        best_age_next   = best_age_reg;
        best_rank_next  = best_rank_reg;
        mod_cnt_next    = mod_cnt_reg;
        mod_rem_next    = mod_rem_reg;
        start_next      = start_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg;
        out_res_next    = out_res_reg;
        out_idle_next   = out_idle_reg;
        ram_we          = 1'b0;
        ram_waddr       = best_idx_reg;
        ram_wdata       = best_word_reg;
        in_ready        = 1'b0;
        upd_word        = best_word_reg;
        runs_on         = 1'b0;

        len_eff = tlen_reg;
        if (tlen_reg < 4'd1) len_eff = 4'd1;
        if (tlen_reg > 4'(TABLE_SLOTS)) len_eff = 4'(TABLE_SLOTS);
        entry  = mod_rem_reg[2:0];
        ql_eff = (qlen_reg == 16'd0) ? 16'd1 : qlen_reg;
        mod_shift = {mod_rem_reg, qcount_reg[~mod_cnt_reg]};

        // evaluation stage of the scan pipeline
        ev_age  = stamp_cnt_reg - rd_word.stamp;
        ev_rank = tqs_pkg::prio_rank(rd_word.prio, start_reg);
        if (state_reg == tqs_pkg::ST_REL)
        begin
            ev_match  = valid_reg[ev_idx_reg] && !ready_reg[ev_idx_reg]
                        && (rd_word.arrival <= qcount_reg);
            ev_better = !best_found_reg || (ev_age > best_age_reg);
        end
        else
        begin
            ev_match  = valid_reg[ev_idx_reg] && ready_reg[ev_idx_reg];
            ev_better = !best_found_reg || (ev_rank < best_rank_reg)
                        || ((ev_rank == best_rank_reg) && (ev_age > best_age_reg));
        end
        scan_end = (scan_cnt_reg == CW'(CAPACITY)) && !ev_vld_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            tqs_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd_next      = cmd;
                    id_next       = task_id;
                    prio_next     = tqs_pkg::clamp_prio(task_priority);
                    rt_next       = run_time;
                    arr_next      = arrival_quantum;
                    scan_cnt_next = '0;
                    res_next      = '0;
                    res_next.quantum_index = qcount_reg;
                    mod_cnt_next  = '0;
                    mod_rem_next  = '0;
                    state_next = (cmd == tqs_pkg::CMD_TICK) ? tqs_pkg::ST_MOD
                                                            : tqs_pkg::ST_FREE;
                end
            end

            tqs_pkg::ST_FREE:
            begin
                // lowest free slot, one valid bit per cycle
                if (scan_cnt_reg == CW'(CAPACITY))
                begin
                    state_next = tqs_pkg::ST_DONE;
                end
                else if (!valid_reg[scan_cnt_reg[IW-1:0]])
                begin
                    ram_we              = 1'b1;
                    ram_waddr           = scan_cnt_reg[IW-1:0];
                    ram_wdata.id        = id_reg;
                    ram_wdata.prio      = prio_reg;
                    ram_wdata.remaining = rt_reg;
                    ram_wdata.arrival   = arr_reg;
                    ram_wdata.stamp     = stamp_cnt_reg;
                    stamp_cnt_next      = stamp_cnt_reg + 32'd1;
                    valid_next[scan_cnt_reg[IW-1:0]] = 1'b1;
                    ready_next[scan_cnt_reg[IW-1:0]] = (arr_reg <= qcount_reg);
                    res_next.accepted   = 1'b1;
                    state_next          = tqs_pkg::ST_DONE;
                end
                else
                begin
                    scan_cnt_next = scan_cnt_reg + CW'(1);
                end
            end

            tqs_pkg::ST_MOD:
            begin
                // restoring remainder of quantum count by table length, one bit a cycle
                if (5'(mod_shift) >= 5'(len_eff))
                begin
                    mod_rem_next = 4'(mod_shift - 5'(len_eff));
                end
                else
                begin
                    mod_rem_next = 4'(mod_shift);
                end
                mod_cnt_next = mod_cnt_reg + 4'd1;
                if (mod_cnt_reg == 4'd15)
                begin
                    scan_cnt_next   = '0;
                    best_found_next = 1'b0;
                    state_next      = tqs_pkg::ST_REL;
                end
            end

            tqs_pkg::ST_REL, tqs_pkg::ST_DSP:
            begin
                if (state_reg == tqs_pkg::ST_REL)
                begin
                    start_next = tqs_pkg::clamp_prio(table_reg[{entry, 2'b00} +: 4]);
                end
                if (scan_cnt_reg != CW'(CAPACITY))
                begin
                    ev_vld_next   = 1'b1;
                    ev_idx_next   = scan_cnt_reg[IW-1:0];
                    scan_cnt_next = scan_cnt_reg + CW'(1);
                end
                if (ev_vld_reg && ev_match && ev_better)
                begin
                    best_found_next = 1'b1;
                    best_idx_next   = ev_idx_reg;
                    best_word_next  = rd_word;
                    best_age_next   = ev_age;
                    best_rank_next  = ev_rank;
                end
                if (scan_end)
                begin
                    state_next = (state_reg == tqs_pkg::ST_REL) ? tqs_pkg::ST_REL_WR
                                                                : tqs_pkg::ST_DSP_WR;
                end
            end

            tqs_pkg::ST_REL_WR:
            begin
                scan_cnt_next   = '0;
                best_found_next = 1'b0;
                if (best_found_reg)
                begin
                    upd_word.stamp = stamp_cnt_reg;
                    ram_we         = 1'b1;
                    ram_wdata      = upd_word;
                    stamp_cnt_next = stamp_cnt_reg + 32'd1;
                    ready_next[best_idx_reg] = 1'b1;
                    state_next     = tqs_pkg::ST_REL;
                end
                else
                begin
                    state_next = tqs_pkg::ST_DSP;
                end
            end

            tqs_pkg::ST_DSP_WR:
            begin
                if (best_found_reg)
                begin
                    res_next.dispatched = 1'b1;
                    res_next.ran_id     = best_word_reg.id;
                    runs_on = best_word_reg.remaining > ql_eff;
                    if (runs_on)
                    begin
                        upd_word.remaining = best_word_reg.remaining - ql_eff;
                        if (best_word_reg.prio < tqs_pkg::PRIO_HIGH)
                        begin
                            upd_word.prio = best_word_reg.prio + 4'd1;
                        end
                        upd_word.stamp = stamp_cnt_reg;
                        ram_we         = 1'b1;
                        ram_wdata      = upd_word;
                        stamp_cnt_next = stamp_cnt_reg + 32'd1;
                        res_next.new_priority = upd_word.prio;
                        res_next.remaining    = upd_word.remaining;
                    end
                    else
                    begin
                        res_next.new_priority = best_word_reg.prio;
                        res_next.finished     = 1'b1;
                        valid_next[best_idx_reg] = 1'b0;
                        ready_next[best_idx_reg] = 1'b0;
                    end
                end
                if (qcount_reg != 16'hFFFF)
                begin
                    qcount_next = qcount_reg + 16'd1;
                end
                state_next = tqs_pkg::ST_DONE;
            end

            tqs_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_res_next   = res_reg;
                    out_idle_next  = ~|valid_reg;
                    state_next     = tqs_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tqs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tqs_pkg::ST_IDLE;
            valid_reg      <= '0;
            ready_reg      <= '0;
            stamp_cnt_reg  <= '0;
            qcount_reg     <= '0;
            scan_cnt_reg   <= '0;
            ev_vld_reg     <= 1'b0;
            best_found_reg <= 1'b0;
            mod_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            ready_reg      <= ready_next;
            stamp_cnt_reg  <= stamp_cnt_next;
            qcount_reg     <= qcount_next;
            scan_cnt_reg   <= scan_cnt_next;
            ev_vld_reg     <= ev_vld_next;
            best_found_reg <= best_found_next;
            mod_cnt_reg    <= mod_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        id_reg        <= id_next;
        prio_reg      <= prio_next;
        rt_reg        <= rt_next;
        arr_reg       <= arr_next;
        ev_idx_reg    <= ev_idx_next;
        best_idx_reg  <= best_idx_next;
        best_word_reg <= best_word_next;
        best_age_reg  <= best_age_next;
        best_rank_reg <= best_rank_next;
        mod_rem_reg   <= mod_rem_next;
        start_reg     <= start_next;
        res_reg       <= res_next;
        out_res_reg   <= out_res_next;
        out_idle_reg  <= out_idle_next;
    end

    assign out_valid     = out_valid_reg;
    assign accepted      = out_res_reg.accepted;
    assign dispatched    = out_res_reg.dispatched;
    assign ran_id        = out_res_reg.ran_id;
    assign new_priority  = out_res_reg.new_priority;
    assign remaining     = out_res_reg.remaining;
    assign finished      = out_res_reg.finished;
    assign idle          = out_idle_reg;
    assign quantum_index = out_res_reg.quantum_index;

    // a submit never dispatches and a tick never stores
    a_kind_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(accepted && dispatched))
        else $error("result both accepted and dispatched");

    a_fin_disp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && finished |-> dispatched && remaining == 16'd0)
        else $error("finished without dispatch or with time left");

    a_requeue_left: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dispatched && !finished |-> remaining != 16'd0)
        else $error("requeued task with no time left");

    a_qcount_step: assert property (@(posedge clk) disable iff (!rst_n)
        qcount_reg != $past(qcount_reg) |-> $past(state_reg) == tqs_pkg::ST_DSP_WR)
        else $error("quantum count moved outside dispatch write");

    a_submit_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tqs_pkg::ST_FREE |-> cmd_reg == tqs_pkg::CMD_SUBMIT)
        else $error("free slot search on a tick");

endmodule
